>>> rtl/json_stream_tokenizer_macros.svh
// ---------------------------------------------------------------------------
// json_stream_tokenizer_macros
// Assertion macros used by the tokenizer back end (jst_back).
// ---------------------------------------------------------------------------
`ifndef JSON_STREAM_TOKENIZER_MACROS_SVH
`define JSON_STREAM_TOKENIZER_MACROS_SVH

// a implies b on the same edge
`define JST_ASSERT_IMP(label, clk, rst_n, a, b, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error(msg);

// a implies b on the next edge
`define JST_ASSERT_NEXT(label, clk, rst_n, a, b, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error(msg);

`endif

>>> rtl/jst_pkg.sv
// ---------------------------------------------------------------------------
// jst_pkg
// Types and constants of the JSON stream tokenizer.
// ---------------------------------------------------------------------------
package jst_pkg;

	localparam int StackDepth = 32;
	localparam int DepthW = 6;
	localparam int MaxRes = 4;

	localparam logic [3:0] EV_NONE = 4'd0;
	localparam logic [3:0] EV_OBJ_OPEN = 4'd1;
	localparam logic [3:0] EV_OBJ_CLOSE = 4'd2;
	localparam logic [3:0] EV_ARR_OPEN = 4'd3;
	localparam logic [3:0] EV_ARR_CLOSE = 4'd4;
	localparam logic [3:0] EV_KEY_BYTE = 4'd5;
	localparam logic [3:0] EV_KEY_END = 4'd6;
	localparam logic [3:0] EV_STR_BYTE = 4'd7;
	localparam logic [3:0] EV_STR_END = 4'd8;
	localparam logic [3:0] EV_INT = 4'd9;
	localparam logic [3:0] EV_NUM_BYTE = 4'd10;
	localparam logic [3:0] EV_REAL_END = 4'd11;
	localparam logic [3:0] EV_TRUE = 4'd12;
	localparam logic [3:0] EV_DOC_DONE = 4'd15;

	localparam logic [3:0] ERR_NONE = 4'd0;
	localparam logic [3:0] ERR_OBJ = 4'd1;
	localparam logic [3:0] ERR_ARR = 4'd2;
	localparam logic [3:0] ERR_STR = 4'd3;
	localparam logic [3:0] ERR_NUM = 4'd4;
	localparam logic [3:0] ERR_LIT = 4'd5;
	localparam logic [3:0] ERR_DEPTH = 4'd6;
	localparam logic [3:0] ERR_EOF = 4'd7;
	localparam logic [3:0] ERR_JSON = 4'd8;

	localparam logic [0:0] REG_MAX_DEPTH = 1'd0;

	typedef struct packed {
		logic [3:0] ev;
		logic [7:0] text;
		logic [DepthW-1:0] level;
		logic [63:0] mag;
		logic neg;
		logic [3:0] err;
		logic last;
	} res_t;

	typedef struct packed {
		logic [1:0] cnt;
		res_t [MaxRes-1:0] res;
	} bundle_t;

endpackage

>>> rtl/json_stream_tokenizer.sv
// ---------------------------------------------------------------------------
// json_stream_tokenizer
// Streaming JSON validator and tokenizer with APB depth-limit register.
// ---------------------------------------------------------------------------
// One byte is accepted per cycle unless a pending bundle waits on a full queue;
// each byte yields zero to four result items, delivered one per cycle while
// the receiver is ready from a two-entry queue, so throughput is one byte per
// cycle while bytes yield at most one item and drops for bytes producing more.
module json_stream_tokenizer import jst_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [1:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [7:0]   s_tdata,   // data_byte
	input  logic         s_tlast,   // end_of_doc
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [79:0]  m_tdata,   // text_byte, nest_level, int_magnitude, int_negative, pad
	output logic [7:0]   m_tuser,   // event_res, error_code
	output logic         m_tlast    // last_of_run
);

	logic [5:0] max_depth_q;
	logic       b_valid, b_ready;
	bundle_t    b_data;
	res_t       o_res;

	assign pready = 1'b1;
	assign prdata = (paddr[1:1] == REG_MAX_DEPTH) ? {26'd0, max_depth_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) max_depth_q <= 6'd32;
		else if (psel && penable && pwrite && paddr[1:1] == REG_MAX_DEPTH && paddr[0] == 1'b0)
			max_depth_q <= pwdata[5:0];
	end

	jst_front u_front (
		.clk, .arst_n, .in_valid(s_tvalid), .in_ready(s_tready), .c(s_tdata),
		.eod(s_tlast), .max_depth(max_depth_q), .b_valid, .b_ready, .b_data
	);

	jst_back u_back (
		.clk, .arst_n, .b_valid, .b_ready, .b_data,
		.o_valid(m_tvalid), .o_ready(m_tready), .o_res
	);

	assign m_tdata = {1'b0, o_res.neg, o_res.mag, o_res.level, o_res.text};
	assign m_tuser = {o_res.err, o_res.ev};
	assign m_tlast = o_res.last;

endmodule

>>> rtl/jst_front.sv
// ---------------------------------------------------------------------------
// jst_front
// Per-byte parser: grammar state, container stack, number accumulate.
// Produces a bundle of up to four results per accepted byte.
// ---------------------------------------------------------------------------
module jst_front import jst_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [7:0]    c,
	input  logic          eod,
	input  logic [5:0]    max_depth,
	output logic          b_valid,
	input  logic          b_ready,
	output bundle_t       b_data
);

	localparam logic [3:0] M_TOP = 4'd0;
	localparam logic [3:0] M_ARR_VAL = 4'd1;
	localparam logic [3:0] M_OBJ_KEY = 4'd2;
	localparam logic [3:0] M_KEY = 4'd3;
	localparam logic [3:0] M_COLON = 4'd4;
	localparam logic [3:0] M_OBJ_VAL = 4'd5;
	localparam logic [3:0] M_STR = 4'd6;
	localparam logic [3:0] M_NUM = 4'd7;
	localparam logic [3:0] M_LIT = 4'd8;
	localparam logic [3:0] M_AFTER = 4'd9;
	localparam logic [3:0] M_DONE = 4'd10;
	localparam logic [3:0] M_ERR = 4'd11;

	localparam logic [3:0] N_SIGN = 4'd1;
	localparam logic [3:0] N_ZERO = 4'd2;
	localparam logic [3:0] N_INT = 4'd3;
	localparam logic [3:0] N_ZERO_NEG = 4'd4;
	localparam logic [3:0] N_INT_NEG = 4'd5;
	localparam logic [3:0] N_DOT = 4'd6;
	localparam logic [3:0] N_FRAC = 4'd7;
	localparam logic [3:0] N_EXP = 4'd8;
	localparam logic [3:0] N_EXPSIGN = 4'd9;
	localparam logic [3:0] N_EXPDIG = 4'd10;

	logic [3:0]  mode_q, mode_n;
	logic [StackDepth-1:0] stack_q, stack_n;
	logic [DepthW-1:0] depth_q, depth_n;
	logic        comma_q, comma_n, esc_q, esc_n;
	logic [1:0]  lkind_q, lkind_n;
	logic [2:0]  lidx_q, lidx_n;
	logic [63:0] acc_q, acc_n;
	logic [3:0]  nflag_q, nflag_n;
	logic [3:0]  err_q, err_n;
	logic        bv_q;
	bundle_t     bd_q, bd_n;

	assign in_ready = !bv_q || b_ready;
	assign b_valid = bv_q;
	assign b_data = bd_q;

	function automatic logic [7:0] lit_char(input logic [1:0] k, input logic [2:0] i);
		logic [7:0] r;
		r = 8'h00;
		case (k)
			2'd1: case (i) 3'd1: r = "r"; 3'd2: r = "u"; 3'd3: r = "e"; default: r = 8'h00; endcase
			2'd2: case (i) 3'd1: r = "a"; 3'd2: r = "l"; 3'd3: r = "s"; 3'd4: r = "e";
				default: r = 8'h00; endcase
			2'd3: case (i) 3'd1: r = "u"; 3'd2: r = "l"; 3'd3: r = "l"; default: r = 8'h00; endcase
			default: r = 8'h00;
		endcase
		return r;
	endfunction

	always_comb begin
		logic ws, dig, nch, arr, key, ip, stop, num_closed, lim_ok;
		logic [3:0] f, d4;
		logic [63:0] x10;
		logic [5:0] limit;
		logic [2:0] llen;
		logic [7:0] v;
		res_t r;
		mode_n = mode_q; stack_n = stack_q; depth_n = depth_q; comma_n = comma_q;
		esc_n = esc_q; lkind_n = lkind_q; lidx_n = lidx_q; acc_n = acc_q;
		nflag_n = nflag_q; err_n = err_q;
		bd_n = '0;
		r = '0;
		stop = 1'b0;
		num_closed = 1'b0;
		ws = (c == 8'h20) || (c == 8'h0a) || (c == 8'h0d) || (c == 8'h09);
		dig = (c >= "0") && (c <= "9");
		d4 = c[3:0];
		nch = dig || c == "+" || c == "-" || c == "." || c == "e" || c == "E";
		f = nflag_q;
		ip = f == N_ZERO || f == N_INT || f == N_ZERO_NEG || f == N_INT_NEG;
		x10 = {acc_q[60:0], 3'b000} + {acc_q[62:0], 1'b0};
		lim_ok = (acc_q < 64'd1844674407370955161) ||
			(acc_q == 64'd1844674407370955161 &&
			 ((f == N_INT) ? (d4 <= 4'd5) : 1'b0)) ||
			(f == N_INT_NEG && acc_q < 64'd922337203685477580) ||
			(f == N_INT_NEG && acc_q == 64'd922337203685477580 && d4 <= 4'd8);
		if (f == N_INT_NEG) lim_ok = (acc_q < 64'd922337203685477580) ||
			(acc_q == 64'd922337203685477580 && d4 <= 4'd8);
		limit = (max_depth < 6'(StackDepth)) ? max_depth : 6'(StackDepth);
		arr = (depth_q != '0) ? stack_q[5'(depth_q - 6'd1)] : 1'b0;
		llen = (lkind_q == 2'd2) ? 3'd5 : 3'd4;
		key = mode_q == M_KEY;
		v = c;

		if (mode_q == M_ERR) begin
			stop = 1'b1;
		end else if (mode_q == M_KEY || mode_q == M_STR) begin
			stop = 1'b1;
			if (esc_q) begin
				esc_n = 1'b0;
				case (c)
					"\"", "\\", "/": v = c;
					"b": v = 8'h08;
					"f": v = 8'h0c;
					"n": v = 8'h0a;
					"r": v = 8'h0d;
					"t": v = 8'h09;
					default: v = 8'h00;
				endcase
				if (c == "\"" || c == "\\" || c == "/" || c == "b" || c == "f" ||
				    c == "n" || c == "r" || c == "t") begin
					r = '0; r.ev = key ? EV_KEY_BYTE : EV_STR_BYTE; r.text = v;
					r.level = depth_q; r.err = err_n;
					bd_n.res[bd_n.cnt] = r; bd_n.cnt = bd_n.cnt + 2'd1;
				end else if (err_n == ERR_NONE) begin
					err_n = ERR_STR; mode_n = M_ERR;
					r = '0; r.level = depth_q; r.err = err_n;
					bd_n.res[bd_n.cnt] = r; bd_n.cnt = bd_n.cnt + 2'd1;
				end
			end else if (c == "\"") begin
				r = '0; r.ev = key ? EV_KEY_END : EV_STR_END; r.level = depth_q;
				r.err = err_n;
				bd_n.res[bd_n.cnt] = r; bd_n.cnt = bd_n.cnt + 2'd1;
				mode_n = key ? M_COLON : ((depth_q != '0) ? M_AFTER : M_DONE);
			end else if (c == "\\") begin
				esc_n = 1'b1;
			end else if (c <= 8'h1f) begin
				err_n = ERR_STR; mode_n = M_ERR;
				r = '0; r.level = depth_q; r.err = err_n;
				bd_n.res[bd_n.cnt] = r; bd_n.cnt = bd_n.cnt + 2'd1;
			end else begin
				r = '0; r.ev = key ? EV_KEY_BYTE : EV_STR_BYTE; r.text = c;
				r.level = depth_q; r.err = err_n;
				bd_n.res[bd_n.cnt] = r; bd_n.cnt = bd_n.cnt + 2'd1;
			end
		end else if (mode_q == M_LIT) begin
			stop = 1'b1;
			if (lkind_q == 2'd0 || lidx_q >= llen || c != lit_char(lkind_q, lidx_q)) begin
				err_n = ERR_LIT; mode_n = M_ERR;
				r = '0; r.level = depth_q; r.err = err_n;
				bd_n.res[bd_n.cnt] = r; bd_n.cnt = bd_n.cnt + 2'd1;
			end else begin
				lidx_n = lidx_q + 3'd1;
				if (lidx_n == llen) begin
					r = '0; r.ev = EV_NUM_BYTE + {2'b00, lkind_q} + 4'd1;
					r.level = depth_q; r.err = err_n;
					bd_n.res[bd_n.cnt] = r; bd_n.cnt = bd_n.cnt + 2'd1;
					lkind_n = '0; lidx_n = '0;
					mode_n = (depth_q != '0) ? M_AFTER : M_DONE;
				end
			end
		end else if (mode_q == M_NUM && nch) begin
			stop = 1'b1;
			if (dig) begin
				if (f == N_SIGN) begin
					nflag_n = (d4 != 4'd0) ? N_INT_NEG : N_ZERO_NEG;
					acc_n = {60'd0, d4};
				end else if (f == N_INT || f == N_INT_NEG) begin
					if (!lim_ok) begin
						err_n = ERR_NUM;
					end else begin
						acc_n = x10 + {60'd0, d4};
					end
				end else if (f == N_DOT || f == N_FRAC) begin
					nflag_n = N_FRAC;
				end else if (f == N_EXP || f == N_EXPSIGN || f == N_EXPDIG) begin
					nflag_n = N_EXPDIG;
				end else begin
					err_n = ERR_NUM;
				end
			end else if (c == ".") begin
				if (!ip) err_n = ERR_NUM; else nflag_n = N_DOT;
			end else if (c == "e" || c == "E") begin
				if (!ip && f != N_FRAC) err_n = ERR_NUM; else nflag_n = N_EXP;
			end else begin
				if (f != N_EXP) err_n = ERR_NUM; else nflag_n = N_EXPSIGN;
			end
			r = '0; r.level = depth_q;
			if (err_n != ERR_NONE) begin
				mode_n = M_ERR; r.err = err_n; nflag_n = nflag_q; acc_n = acc_q;
			end else begin
				r.ev = EV_NUM_BYTE; r.text = c; r.err = err_n;
			end
			bd_n.res[bd_n.cnt] = r; bd_n.cnt = bd_n.cnt + 2'd1;
		end else if (mode_q == M_NUM) begin
			num_closed = 1'b1;
		end

		if (num_closed) begin
			r = '0; r.level = depth_q;
			if (ip) begin
				r.ev = EV_INT; r.mag = acc_q;
				r.neg = (f == N_ZERO_NEG || f == N_INT_NEG);
			end else if (f == N_FRAC || f == N_EXPDIG) begin
				r.ev = EV_REAL_END;
			end else begin
				err_n = ERR_NUM; mode_n = M_ERR; stop = 1'b1;
			end
			r.err = err_n;
			bd_n.res[bd_n.cnt] = r; bd_n.cnt = bd_n.cnt + 2'd1;
			if (!stop) begin
				acc_n = '0; nflag_n = '0;
				mode_n = (depth_q != '0) ? M_AFTER : M_DONE;
			end
		end

		if (!stop && !ws) begin
			// mode_n is current mode after a possible number close
			logic is_val, bad;
			logic [3:0] verr;
			is_val = 1'b0; bad = 1'b0; verr = ERR_JSON;
			case (mode_n)
				M_TOP: begin is_val = 1'b1; verr = ERR_JSON; end
				M_OBJ_VAL: begin is_val = 1'b1; verr = ERR_OBJ; end
				M_ARR_VAL: begin
					if (c == "]") begin
						if (comma_q) begin bad = 1'b1; verr = ERR_JSON; end
						else begin
							depth_n = depth_q - 6'd1; comma_n = 1'b0;
							r = '0; r.ev = EV_ARR_CLOSE; r.level = depth_n; r.err = err_n;
							bd_n.res[bd_n.cnt] = r; bd_n.cnt = bd_n.cnt + 2'd1;
							mode_n = (depth_n != '0) ? M_AFTER : M_DONE;
						end
					end else begin is_val = 1'b1; verr = ERR_ARR; end
				end
				M_OBJ_KEY: begin
					if (c == "}") begin
						if (comma_q) begin bad = 1'b1; verr = ERR_JSON; end
						else begin
							depth_n = depth_q - 6'd1; comma_n = 1'b0;
							r = '0; r.ev = EV_OBJ_CLOSE; r.level = depth_n; r.err = err_n;
							bd_n.res[bd_n.cnt] = r; bd_n.cnt = bd_n.cnt + 2'd1;
							mode_n = (depth_n != '0) ? M_AFTER : M_DONE;
						end
					end else if (c == "\"") begin
						comma_n = 1'b0; esc_n = 1'b0; mode_n = M_KEY;
					end else begin bad = 1'b1; verr = ERR_OBJ; end
				end
				M_COLON: begin
					if (c == ":") mode_n = M_OBJ_VAL;
					else begin bad = 1'b1; verr = ERR_OBJ; end
				end
				M_AFTER: begin
					if (c == ",") begin
						comma_n = 1'b1; mode_n = arr ? M_ARR_VAL : M_OBJ_KEY;
					end else if ((arr && c == "]") || (!arr && c == "}")) begin
						depth_n = depth_q - 6'd1; comma_n = 1'b0;
						r = '0; r.ev = arr ? EV_ARR_CLOSE : EV_OBJ_CLOSE; r.level = depth_n;
						r.err = err_n;
						bd_n.res[bd_n.cnt] = r; bd_n.cnt = bd_n.cnt + 2'd1;
						mode_n = (depth_n != '0) ? M_AFTER : M_DONE;
					end else begin bad = 1'b1; verr = arr ? ERR_ARR : ERR_OBJ; end
				end
				default: begin bad = 1'b1; verr = ERR_JSON; end
			endcase
			if (is_val) begin
				comma_n = 1'b0;
				if (c == "{" || c == "[") begin
					if (depth_q >= limit) begin
						bad = 1'b1; verr = ERR_DEPTH;
					end else begin
						stack_n[5'(depth_q)] = (c == "[");
						depth_n = depth_q + 6'd1;
						r = '0; r.ev = (c == "[") ? EV_ARR_OPEN : EV_OBJ_OPEN;
						r.level = depth_n; r.err = err_n;
						bd_n.res[bd_n.cnt] = r; bd_n.cnt = bd_n.cnt + 2'd1;
						mode_n = (c == "[") ? M_ARR_VAL : M_OBJ_KEY;
					end
				end else if (c == "\"") begin
					esc_n = 1'b0; mode_n = M_STR;
				end else if (c == "-" || dig) begin
					acc_n = (c == "-" || c == "0") ? 64'd0 : {60'd0, d4};
					nflag_n = (c == "-") ? N_SIGN : (c == "0") ? N_ZERO : N_INT;
					mode_n = M_NUM;
					r = '0; r.ev = EV_NUM_BYTE; r.text = c; r.level = depth_q; r.err = err_n;
					bd_n.res[bd_n.cnt] = r; bd_n.cnt = bd_n.cnt + 2'd1;
				end else if (c == "t" || c == "f" || c == "n") begin
					lkind_n = (c == "t") ? 2'd1 : (c == "f") ? 2'd2 : 2'd3;
					lidx_n = 3'd1; mode_n = M_LIT;
				end else begin
					bad = 1'b1;
				end
			end
			if (bad) begin
				err_n = verr; mode_n = M_ERR;
				r = '0; r.level = depth_n; r.err = err_n;
				bd_n.res[bd_n.cnt] = r; bd_n.cnt = bd_n.cnt + 2'd1;
			end
		end

		if (eod) begin
			if (mode_n == M_NUM) begin
				r = '0; r.level = depth_n;
				if (nflag_n == N_ZERO || nflag_n == N_INT || nflag_n == N_ZERO_NEG ||
				    nflag_n == N_INT_NEG) begin
					r.ev = EV_INT; r.mag = acc_n;
					r.neg = (nflag_n == N_ZERO_NEG || nflag_n == N_INT_NEG);
					mode_n = (depth_n != '0) ? M_AFTER : M_DONE;
				end else if (nflag_n == N_FRAC || nflag_n == N_EXPDIG) begin
					r.ev = EV_REAL_END;
					mode_n = (depth_n != '0) ? M_AFTER : M_DONE;
				end else begin
					err_n = ERR_NUM; mode_n = M_ERR;
				end
				r.err = err_n;
				bd_n.res[bd_n.cnt] = r; bd_n.cnt = bd_n.cnt + 2'd1;
			end
			if (mode_n != M_DONE && mode_n != M_ERR) begin
				err_n = ERR_EOF;
				r = '0; r.level = depth_n; r.err = err_n;
				bd_n.res[bd_n.cnt] = r; bd_n.cnt = bd_n.cnt + 2'd1;
			end
			r = '0; r.ev = EV_DOC_DONE; r.level = depth_n; r.err = err_n; r.last = 1'b1;
			bd_n.res[bd_n.cnt] = r;
			mode_n = M_TOP; depth_n = '0; comma_n = 1'b0; esc_n = 1'b0; lkind_n = '0;
			lidx_n = '0; acc_n = '0; nflag_n = '0; err_n = ERR_NONE;
		end else if (bd_n.cnt != 2'd0) begin
			bd_n.res[bd_n.cnt - 2'd1].last = 1'b1;
			bd_n.cnt = bd_n.cnt - 2'd1;
		end
	end

	// cnt holds number of results minus one; eod always emits, so count is cnt+1
	logic has_res;
	assign has_res = eod || (bd_n.res[0].last | bd_n.res[1].last | bd_n.res[2].last |
		bd_n.res[3].last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_TOP; depth_q <= '0; comma_q <= 1'b0; esc_q <= 1'b0;
			lkind_q <= '0; lidx_q <= '0; acc_q <= '0; nflag_q <= '0; err_q <= ERR_NONE;
			bv_q <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				mode_q <= mode_n; depth_q <= depth_n; comma_q <= comma_n; esc_q <= esc_n;
				lkind_q <= lkind_n; lidx_q <= lidx_n; acc_q <= acc_n; nflag_q <= nflag_n;
				err_q <= err_n;
				bv_q <= has_res;
			end else if (b_ready) begin
				bv_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			stack_q <= stack_n;
			bd_q <= bd_n;
		end
	end

endmodule

>>> rtl/jst_back.sv
// ---------------------------------------------------------------------------
// jst_back
// Bundle queue and result serializer: drains up to four results per byte.
// ---------------------------------------------------------------------------
module jst_back import jst_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    b_valid,
	output logic    b_ready,
	input  bundle_t b_data,
	output logic    o_valid,
	input  logic    o_ready,
	output res_t    o_res
);

`include "json_stream_tokenizer_macros.svh"

	bundle_t    fifo_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic [1:0] idx_q;
	logic       push, pop, take;
	bundle_t    head;

	assign b_ready = cnt_q != 2'd2;
	assign push = b_valid && b_ready;
	assign head = fifo_q[rp_q];
	assign o_valid = cnt_q != 2'd0;
	assign o_res = head.res[idx_q];
	assign take = o_valid && o_ready;
	assign pop = take && (idx_q == head.cnt);

	always_ff @(posedge clk) begin
		if (push) fifo_q[wp_q] <= b_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= '0; idx_q <= '0;
		end else begin
			if (push) wp_q <= !wp_q;
			if (pop) rp_q <= !rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
			if (pop) idx_q <= '0;
			else if (take) idx_q <= idx_q + 2'd1;
		end
	end

	`JST_ASSERT_IMP(a_last_on_pop, clk, arst_n, pop, o_res.last, "pop without last")
	`JST_ASSERT_IMP(a_no_last_mid, clk, arst_n, take && !pop, !o_res.last, "last mid run")
	`JST_ASSERT_NEXT(a_no_overflow, clk, arst_n, cnt_q == 2'd2 && !pop, cnt_q == 2'd2,
		"queue count")

endmodule

>>> bench/json_stream_tokenizer_checker.sv
// ----------------------------------------------------------------------------
// json_stream_tokenizer_checker
// Watches the byte, event and register channels of the tokenizer, predicts
// the event items of every accepted byte and compares them in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module json_stream_tokenizer_checker import jst_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [1:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        pready,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,
	input  logic        s_tlast,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [79:0] m_tdata,
	input  logic [7:0]  m_tuser,
	input  logic        m_tlast,
	output int          fails,
	output int          pending
);

	typedef enum int {
		P_TOP, P_ARR, P_OKEY, P_KEY, P_COLON, P_OVAL, P_STR, P_NUM, P_LIT, P_AFTER,
		P_DONE, P_ERR
	} pmode_e;

	typedef enum int {
		N_NONE, N_SIGN, N_ZERO, N_INT, N_ZERO_NEG, N_INT_NEG, N_DOT, N_FRAC, N_EXP,
		N_EXPSIGN, N_EXPDIG
	} nphase_e;

	pmode_e       mode;
	nphase_e      nph;
	bit           stk [StackDepth];
	int unsigned  depth;
	bit           comma;
	bit           esc;
	int unsigned  lit_kind;
	int unsigned  lit_idx;
	logic [63:0]  accum;
	logic [3:0]   err_l;
	logic [5:0]   depth_lim;
	res_t         step_res [$];
	res_t         events_due [$];

	assign pending = events_due.size();

	function automatic void emit(logic [3:0] ev, logic [7:0] txt, logic [63:0] mag, bit neg);
		res_t r;
		if (step_res.size() >= MaxRes)
			return;
		r.ev = ev;
		r.text = txt;
		r.level = depth[5:0];
		r.mag = mag;
		r.neg = neg;
		r.err = err_l;
		r.last = 1'b0;
		step_res.push_back(r);
	endfunction

	function automatic void fail_doc(logic [3:0] code);
		if (err_l != ERR_NONE)
			return;
		err_l = code;
		mode = P_ERR;
		emit(EV_NONE, 8'h00, 64'd0, 1'b0);
	endfunction

	function automatic void value_done();
		mode = (depth != 0) ? P_AFTER : P_DONE;
	endfunction

	function automatic void open_cont(bit is_arr);
		int unsigned lim;
		lim = (depth_lim < StackDepth) ? depth_lim : StackDepth;
		if (depth >= lim) begin
			fail_doc(ERR_DEPTH);
			return;
		end
		stk[depth] = is_arr;
		depth++;
		comma = 1'b0;
		emit(is_arr ? EV_ARR_OPEN : EV_OBJ_OPEN, 8'h00, 64'd0, 1'b0);
		mode = is_arr ? P_ARR : P_OKEY;
	endfunction

	function automatic void close_cont(bit is_arr);
		if (depth > 0)
			depth--;
		comma = 1'b0;
		emit(is_arr ? EV_ARR_CLOSE : EV_OBJ_CLOSE, 8'h00, 64'd0, 1'b0);
		value_done();
	endfunction

	function automatic bit is_dig(logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic bit is_ws(logic [7:0] c);
		return c == " " || c == 8'h0a || c == 8'h0d || c == 8'h09;
	endfunction

	function automatic bit int_ph(nphase_e f);
		return f == N_ZERO || f == N_INT || f == N_ZERO_NEG || f == N_INT_NEG;
	endfunction

	function automatic void num_feed(logic [7:0] c);
		nphase_e f;
		logic [63:0] d;
		logic [63:0] lim;
		f = nph;
		d = 64'(c - "0");
		if (is_dig(c)) begin
			if (f == N_SIGN) begin
				f = (d != 0) ? N_INT_NEG : N_ZERO_NEG;
				accum = d;
			end else if (f == N_INT || f == N_INT_NEG) begin
				lim = (f == N_INT) ? 64'hffff_ffff_ffff_ffff : 64'h8000_0000_0000_0000;
				if (accum > (lim - d) / 10) begin
					fail_doc(ERR_NUM);
					return;
				end
				accum = accum * 10 + d;
			end else if (f == N_DOT || f == N_FRAC) begin
				f = N_FRAC;
			end else if (f == N_EXP || f == N_EXPSIGN || f == N_EXPDIG) begin
				f = N_EXPDIG;
			end else begin
				fail_doc(ERR_NUM);
				return;
			end
		end else if (c == ".") begin
			if (!int_ph(f)) begin
				fail_doc(ERR_NUM);
				return;
			end
			f = N_DOT;
		end else if (c == "e" || c == "E") begin
			if (!int_ph(f) && f != N_FRAC) begin
				fail_doc(ERR_NUM);
				return;
			end
			f = N_EXP;
		end else begin
			if (f != N_EXP) begin
				fail_doc(ERR_NUM);
				return;
			end
			f = N_EXPSIGN;
		end
		nph = f;
		emit(EV_NUM_BYTE, c, 64'd0, 1'b0);
	endfunction

	function automatic void num_finish();
		if (int_ph(nph))
			emit(EV_INT, 8'h00, accum, nph == N_ZERO_NEG || nph == N_INT_NEG);
		else if (nph == N_FRAC || nph == N_EXPDIG)
			emit(EV_REAL_END, 8'h00, 64'd0, 1'b0);
		else begin
			fail_doc(ERR_NUM);
			return;
		end
		accum = 0;
		nph = N_NONE;
		value_done();
	endfunction

	function automatic void start_value(logic [7:0] c, logic [3:0] code);
		comma = 1'b0;
		if (c == "{")
			open_cont(1'b0);
		else if (c == "[")
			open_cont(1'b1);
		else if (c == "\"") begin
			esc = 1'b0;
			mode = P_STR;
		end else if (c == "-" || is_dig(c)) begin
			accum = (c == "-" || c == "0") ? 64'd0 : 64'(c - "0");
			nph = (c == "-") ? N_SIGN : (c == "0") ? N_ZERO : N_INT;
			mode = P_NUM;
			emit(EV_NUM_BYTE, c, 64'd0, 1'b0);
		end else if (c == "t" || c == "f" || c == "n") begin
			lit_kind = (c == "t") ? 1 : (c == "f") ? 2 : 3;
			lit_idx = 1;
			mode = P_LIT;
		end else
			fail_doc(code);
	endfunction

	function automatic void str_byte(logic [7:0] c, bit key);
		logic [7:0] v;
		if (esc) begin
			esc = 1'b0;
			case (c)
				"\"", "\\", "/": v = c;
				"b": v = 8'h08;
				"f": v = 8'h0c;
				"n": v = 8'h0a;
				"r": v = 8'h0d;
				"t": v = 8'h09;
				default: begin
					fail_doc(ERR_STR);
					return;
				end
			endcase
			emit(key ? EV_KEY_BYTE : EV_STR_BYTE, v, 64'd0, 1'b0);
		end else if (c == "\"") begin
			emit(key ? EV_KEY_END : EV_STR_END, 8'h00, 64'd0, 1'b0);
			if (key)
				mode = P_COLON;
			else
				value_done();
		end else if (c == "\\")
			esc = 1'b1;
		else if (c <= 8'h1f)
			fail_doc(ERR_STR);
		else
			emit(key ? EV_KEY_BYTE : EV_STR_BYTE, c, 64'd0, 1'b0);
	endfunction

	function automatic void lit_byte(logic [7:0] c);
		string word;
		word = (lit_kind == 1) ? "true" : (lit_kind == 2) ? "false" : "null";
		if (lit_kind < 1 || lit_kind > 3 || lit_idx >= word.len() || c != word[lit_idx]) begin
			fail_doc(ERR_LIT);
			return;
		end
		lit_idx++;
		if (lit_idx == word.len()) begin
			emit(4'(EV_TRUE + lit_kind - 1), 8'h00, 64'd0, 1'b0);
			lit_kind = 0;
			lit_idx = 0;
			value_done();
		end
	endfunction

	function automatic void take_byte(logic [7:0] c);
		bit arr;
		case (mode)
			P_ERR: return;
			P_KEY: begin
				str_byte(c, 1'b1);
				return;
			end
			P_STR: begin
				str_byte(c, 1'b0);
				return;
			end
			P_LIT: begin
				lit_byte(c);
				return;
			end
			P_NUM: begin
				if (is_dig(c) || c == "+" || c == "-" || c == "." || c == "e" || c == "E") begin
					num_feed(c);
					return;
				end
				num_finish();
				if (mode == P_ERR)
					return;
			end
			default: ;
		endcase
		if (is_ws(c))
			return;
		case (mode)
			P_TOP: start_value(c, ERR_JSON);
			P_OVAL: start_value(c, ERR_OBJ);
			P_ARR: begin
				if (c == "]") begin
					if (comma)
						fail_doc(ERR_JSON);
					else
						close_cont(1'b1);
				end else
					start_value(c, ERR_ARR);
			end
			P_OKEY: begin
				if (c == "}") begin
					if (comma)
						fail_doc(ERR_JSON);
					else
						close_cont(1'b0);
				end else if (c == "\"") begin
					comma = 1'b0;
					esc = 1'b0;
					mode = P_KEY;
				end else
					fail_doc(ERR_OBJ);
			end
			P_COLON: begin
				if (c == ":")
					mode = P_OVAL;
				else
					fail_doc(ERR_OBJ);
			end
			P_AFTER: begin
				arr = (depth > 0 && depth <= StackDepth) ? stk[depth-1] : 1'b0;
				if (c == ",") begin
					comma = 1'b1;
					mode = arr ? P_ARR : P_OKEY;
				end else if (arr && c == "]")
					close_cont(1'b1);
				else if (!arr && c == "}")
					close_cont(1'b0);
				else
					fail_doc(arr ? ERR_ARR : ERR_OBJ);
			end
			default: fail_doc(ERR_JSON);
		endcase
	endfunction

	function automatic void doc_clear();
		mode = P_TOP;
		depth = 0;
		comma = 1'b0;
		esc = 1'b0;
		lit_kind = 0;
		lit_idx = 0;
		accum = 0;
		nph = N_NONE;
		err_l = ERR_NONE;
	endfunction

	function automatic void predict_byte(logic [7:0] c, bit eod);
		step_res.delete();
		take_byte(c);
		if (eod) begin
			if (mode == P_NUM)
				num_finish();
			if (mode != P_DONE && mode != P_ERR)
				fail_doc(ERR_EOF);
			emit(EV_DOC_DONE, 8'h00, 64'd0, 1'b0);
			doc_clear();
		end
		if (step_res.size() > 0)
			step_res[step_res.size()-1].last = 1'b1;
		foreach (step_res[i])
			events_due.push_back(step_res[i]);
	endfunction

	function automatic void compare_event();
		res_t got;
		res_t exp_r;
		got.text = m_tdata[7:0];
		got.level = m_tdata[13:8];
		got.mag = m_tdata[77:14];
		got.neg = m_tdata[78];
		got.ev = m_tuser[3:0];
		got.err = m_tuser[7:4];
		got.last = m_tlast;
		if (events_due.size() == 0) begin
			fails++;
			if (fails <= 10)
				$display("unexpected event item: ev=%0d text=%h err=%0d", got.ev, got.text,
					got.err);
			return;
		end
		exp_r = events_due.pop_front();
		if (got !== exp_r) begin
			fails++;
			if (fails <= 10)
				$display({"event mismatch: exp ev=%0d text=%h lvl=%0d mag=%0d neg=%b err=%0d ",
					"last=%b / got ev=%0d text=%h lvl=%0d mag=%0d neg=%b err=%0d last=%b"},
					exp_r.ev, exp_r.text, exp_r.level, exp_r.mag, exp_r.neg, exp_r.err,
					exp_r.last, got.ev, got.text, got.level, got.mag, got.neg, got.err,
					got.last);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			doc_clear();
			depth_lim = 6'd32;
			fails = 0;
			events_due.delete();
			foreach (stk[i])
				stk[i] = 1'b0;
		end else begin
			if (psel && penable && pwrite && pready && paddr == 2'(4 * REG_MAX_DEPTH))
				depth_lim = pwdata[5:0];
			if (m_tvalid && m_tready)
				compare_event();
			if (s_tvalid && s_tready)
				predict_byte(s_tdata, s_tlast);
		end
	end

endmodule

>>> bench/json_stream_tokenizer_tb.sv
// ----------------------------------------------------------------------------
// json_stream_tokenizer_tb
// Feeds short directed documents and random JSON documents (well-formed,
// corrupted and noise) under several depth limits, with random stalls on
// both sides and one long receiver hold-off; the checker does the scoring.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module json_stream_tokenizer_tb;
	import jst_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [1:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;   // data_byte
	logic        s_tlast;   // end_of_doc
	logic        m_tvalid;
	logic        m_tready;
	logic [79:0] m_tdata;   // text_byte, nest_level, int_magnitude, int_negative, pad
	logic [7:0]  m_tuser;   // event_res, error_code
	logic        m_tlast;   // last_of_run
	int          fails;
	int          pending;
	int          bytes_sent;
	int          hold_cnt;
	int          stall_cnt;
	bit          hold_done;
	byte unsigned doc_q [$];

	json_stream_tokenizer uut (.*);

	json_stream_tokenizer_checker chk (.*);

	initial clk = 1'b0;
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	initial begin
		#2ms;
		$display("[json_stream_tokenizer] ERROR");
		$finish;
	end

	// receiver: random stalls, one long hold-off once traffic is flowing
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			hold_cnt <= 0;
			stall_cnt <= 0;
			hold_done <= 1'b0;
		end else if (!hold_done && bytes_sent >= 120) begin
			hold_done <= 1'b1;
			hold_cnt <= 300;
			m_tready <= 1'b0;
		end else if (hold_cnt > 0) begin
			hold_cnt <= hold_cnt - 1;
			m_tready <= 1'b0;
		end else if (stall_cnt > 0) begin
			stall_cnt <= stall_cnt - 1;
			m_tready <= 1'b0;
		end else if ($urandom_range(0, 9) < 2) begin
			stall_cnt <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) :
				$urandom_range(0, 3);
			m_tready <= 1'b0;
		end else
			m_tready <= 1'b1;
	end

	task automatic apb_write(logic [1:0] addr, logic [31:0] val);
		@(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= addr;
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic send_doc();
		int g;
		foreach (doc_q[i]) begin
			s_tdata <= doc_q[i];
			s_tlast <= (i == doc_q.size() - 1);
			s_tvalid <= 1'b1;
			do
				@(posedge clk);
			while (!s_tready);
			bytes_sent++;
			g = ($urandom_range(0, 19) == 0) ? $urandom_range(8, 25) :
				($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
			if (g > 0) begin
				s_tvalid <= 1'b0;
				repeat (g) @(posedge clk);
			end
		end
		s_tvalid <= 1'b0;
		doc_q.delete();
	endtask

	task automatic drain();
		while (pending != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	function automatic void put_text(string s);
		for (int i = 0; i < s.len(); i++)
			doc_q.push_back(s[i]);
	endfunction

	function automatic void put_ws();
		case ($urandom_range(0, 7))
			0: doc_q.push_back(" ");
			1: doc_q.push_back(8'h0a);
			2: doc_q.push_back(8'h09);
			3: doc_q.push_back(8'h0d);
			default: ;
		endcase
	endfunction

	function automatic void put_dec(logic [63:0] v);
		string s;
		s = "";
		do begin
			s = {string'(byte'("0" + v % 10)), s};
			v = v / 10;
		end while (v != 0);
		put_text(s);
	endfunction

	function automatic void gen_num();
		case ($urandom_range(0, 11))
			0: put_text("18446744073709551615");
			1: put_text("18446744073709551616");
			2: put_text("-9223372036854775808");
			3: put_text("-9223372036854775809");
			4: put_text("-0");
			5: put_text("0");
			6: put_dec({$urandom, $urandom});
			7: begin
				doc_q.push_back("-");
				put_dec($urandom_range(1, 99999));
			end
			8: begin
				put_dec($urandom_range(0, 99));
				put_text(".");
				put_dec($urandom_range(0, 999));
			end
			9: begin
				put_dec($urandom_range(1, 9));
				put_text($urandom_range(0, 1) ? "e" : "E");
				case ($urandom_range(0, 2))
					0: put_text("+");
					1: put_text("-");
					default: ;
				endcase
				put_dec($urandom_range(0, 30));
			end
			10: put_text($urandom_range(0, 1) ? "0.5e-2" : "-3.25E7");
			default: put_dec($urandom_range(1, 1000));
		endcase
	endfunction

	function automatic void gen_str();
		int n;
		n = $urandom_range(0, 5);
		doc_q.push_back("\"");
		repeat (n) begin
			case ($urandom_range(0, 9))
				0: begin
					doc_q.push_back("\\");
					case ($urandom_range(0, 7))
						0: doc_q.push_back("\"");
						1: doc_q.push_back("\\");
						2: doc_q.push_back("/");
						3: doc_q.push_back("b");
						4: doc_q.push_back("f");
						5: doc_q.push_back("n");
						6: doc_q.push_back("r");
						default: doc_q.push_back("t");
					endcase
				end
				1: doc_q.push_back(byte'($urandom_range(8'h80, 8'hff)));
				default: doc_q.push_back(byte'($urandom_range(8'h23, 8'h5b)));
			endcase
		end
		doc_q.push_back("\"");
	endfunction

	function automatic void gen_value(int lvl);
		int r;
		int n;
		r = $urandom_range(0, 9);
		put_ws();
		if (lvl > 0 && r < 2) begin
			doc_q.push_back("{");
			n = $urandom_range(0, 3);
			for (int i = 0; i < n; i++) begin
				if (i > 0)
					doc_q.push_back(",");
				put_ws();
				gen_str();
				put_ws();
				doc_q.push_back(":");
				gen_value(lvl - 1);
			end
			put_ws();
			doc_q.push_back("}");
		end else if (lvl > 0 && r < 4) begin
			doc_q.push_back("[");
			n = $urandom_range(0, 3);
			for (int i = 0; i < n; i++) begin
				if (i > 0)
					doc_q.push_back(",");
				gen_value(lvl - 1);
			end
			put_ws();
			doc_q.push_back("]");
		end else if (r < 6)
			gen_num();
		else if (r < 8)
			gen_str();
		else
			case ($urandom_range(0, 2))
				0: put_text("true");
				1: put_text("false");
				default: put_text("null");
			endcase
		put_ws();
	endfunction

	function automatic void gen_doc(int lim);
		int r;
		int n;
		r = $urandom_range(0, 19);
		if (r == 0) begin
			repeat ($urandom_range(1, 6))
				doc_q.push_back(byte'($urandom_range(0, 255)));
		end else if (r == 1) begin
			n = lim + $urandom_range(0, 1);
			repeat (n) doc_q.push_back($urandom_range(0, 1) ? "[" : "{");
			if (n > 0 && doc_q[n-1] == "{")
				doc_q[n-1] = "[";
			for (int i = n - 1; i >= 0; i--)
				if (doc_q[i] == "[")
					doc_q.push_back("]");
				else
					put_text("\"k\":0}");
		end else begin
			gen_value($urandom_range(1, 3));
			if (r < 7) begin
				case ($urandom_range(0, 3))
					0: doc_q[$urandom_range(0, doc_q.size() - 1)] = byte'($urandom_range(0, 255));
					1: if (doc_q.size() > 1)
						void'(doc_q.pop_back());
					2: put_text(" x");
					default: begin
						if (doc_q.size() > 2)
							doc_q.insert($urandom_range(1, doc_q.size() - 1), ",");
					end
				endcase
			end
		end
	endfunction

	initial begin
		int lims [5] = '{32, 1, 0, 3, 63};
		string directed [7] = '{"[1,]", "01", " ", "{\"a\":tx}", "\"\\q\"", "1 x", "-"};
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tlast = 1'b0;
		bytes_sent = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed[i]) begin
			put_text(directed[i]);
			send_doc();
		end
		doc_q.push_back(8'h22);
		doc_q.push_back(8'h01);
		doc_q.push_back(8'h22);
		send_doc();
		foreach (lims[p]) begin
			drain();
			apb_write(2'(4 * REG_MAX_DEPTH), 32'(lims[p]));
			while (bytes_sent < 30 + 62 * (p + 1)) begin
				gen_doc(lims[p] > StackDepth ? StackDepth : lims[p]);
				send_doc();
			end
		end
		drain();
		repeat (10) @(posedge clk);
		if (fails == 0 && pending == 0)
			$display("[json_stream_tokenizer] OK");
		else
			$display("[json_stream_tokenizer] ERROR");
		$finish;
	end

endmodule

>>> filelist.f
+incdir+rtl
rtl/jst_pkg.sv
rtl/jst_front.sv
rtl/jst_back.sv
rtl/json_stream_tokenizer.sv
bench/json_stream_tokenizer_checker.sv
bench/json_stream_tokenizer_tb.sv
